@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define LRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen out of reset
`define LRS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define LRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hdl/lrs_pkg.sv @@
package lrs_pkg;

    // fixed field widths
    localparam int COL_W = 6;
    localparam int CFG_W = 7;
    localparam int SLOT_W = 2;

    // minimum row width and reset value
    localparam logic [CFG_W-1:0] MIN_WIDTH = 7'd3;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;

    // physical row slots in each memory entry
    localparam int SLOT_N = 3;

    // control from the writer to the emitter
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] slot_up;
        logic [SLOT_W-1:0] slot_mid;
        logic [SLOT_W-1:0] slot_down;
        logic [CFG_W-1:0]  len_up;
        logic [CFG_W-1:0]  len_mid;
        logic [CFG_W-1:0]  len_down;
    } t_emit_ctl;

    // next slot in the ring of three
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == 2'd2) ? 2'd0 : s + 2'd1;
        return r;
    endfunction

endpackage

@@ hdl/lrs_cell_if.sv @@
interface lrs_cell_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic slab_start;

    modport source (output valid, output cell_alive, output slab_start, input ready);
    modport sink (input valid, input cell_alive, input slab_start, output ready);
endinterface

@@ hdl/lrs_result_if.sv @@
interface lrs_result_if;
    logic                     valid;
    logic                     ready;
    logic                     next_alive;
    logic [lrs_pkg::COL_W-1:0] cell_column;
    logic                     row_done;

    modport source (output valid, output next_alive, output cell_column, output row_done,
                    input ready);
    modport sink (input valid, input next_alive, input cell_column, input row_done,
                  output ready);
endinterface

@@ hdl/lrs_cfg_if.sv @@
interface lrs_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [lrs_pkg::CFG_W-1:0] row_width;

    modport source (output valid, output row_width, input ready);
    modport sink (input valid, input row_width, output ready);
endinterface

@@ hdl/lrs_row_mem.sv @@
module lrs_row_mem #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [lrs_pkg::COL_W-1:0]   i_rd_col,
    output logic [lrs_pkg::SLOT_N-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [lrs_pkg::COL_W-1:0]   i_wr_col,
    input  logic [lrs_pkg::SLOT_N-1:0]  i_wr_data
);

    localparam int AW = $clog2(DEPTH);

    // one entry per column, one bit per row slot
    logic [lrs_pkg::SLOT_N-1:0] mem [DEPTH];
    logic [lrs_pkg::SLOT_N-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_col[AW-1:0]] <= i_wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_col[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/lrs_writer.sv @@
`include "assert_macros.svh"

module lrs_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lrs_cell_if.sink                    i_cell,
    input  logic [lrs_pkg::COL_W-1:0]   i_w_m1,
    output logic                        o_rd_en,
    output logic [lrs_pkg::COL_W-1:0]   o_rd_col,
    input  logic [lrs_pkg::SLOT_N-1:0]  i_rd_data,
    output logic                        o_wr_en,
    output logic [lrs_pkg::COL_W-1:0]   o_wr_col,
    output logic [lrs_pkg::SLOT_N-1:0]  o_wr_data,
    output lrs_pkg::t_emit_ctl          o_ctl,
    input  logic                        i_emit_done
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WRITE = 3'b010,
        ST_EMIT  = 3'b100
    } t_wr_state;

    t_wr_state                    r_state, n_state;
    logic [lrs_pkg::COL_W-1:0]    r_col;
    logic [1:0]                   r_rows_seen;
    logic [lrs_pkg::SLOT_W-1:0]   r_slot_new;
    logic [lrs_pkg::CFG_W-1:0]    r_len [lrs_pkg::SLOT_N];
    logic [lrs_pkg::COL_W-1:0]    r_wcol;
    logic                         r_alive;
    logic                         r_last;
    logic                         r_emit;

    logic                         accept;
    logic [lrs_pkg::COL_W-1:0]    col_eff;
    logic [1:0]                   rows_eff;
    logic                         last;
    logic [lrs_pkg::SLOT_W-1:0]   slot_nx;
    logic                         rotate;

    // request decode
    assign accept   = i_cell.valid && i_cell.ready;
    assign col_eff  = i_cell.slab_start ? '0 : r_col;
    assign rows_eff = i_cell.slab_start ? 2'd0 : r_rows_seen;
    assign last     = (col_eff >= i_w_m1);
    assign slot_nx  = lrs_pkg::slot_inc(r_slot_new);

    assign i_cell.ready = (r_state == ST_IDLE);

    // read half of the read-modify-write
    assign o_rd_en  = accept;
    assign o_rd_col = col_eff;

    // write half: replace the bit of the row being built
    assign o_wr_en  = (r_state == ST_WRITE);
    assign o_wr_col = r_wcol;
    always_comb begin
        o_wr_data = i_rd_data;
        o_wr_data[r_slot_new] = r_alive;
    end

    // emission control
    always_comb begin
        o_ctl.start     = (r_state == ST_WRITE) && r_last && r_emit;
        o_ctl.slot_down = r_slot_new;
        o_ctl.slot_up   = slot_nx;
        o_ctl.slot_mid  = lrs_pkg::slot_inc(slot_nx);
        o_ctl.len_down  = r_len[r_slot_new];
        o_ctl.len_up    = r_len[slot_nx];
        o_ctl.len_mid   = r_len[lrs_pkg::slot_inc(slot_nx)];
    end

    // state sequencing
    always_comb begin
        n_state = r_state;
        rotate  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_last && r_emit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                    rotate  = r_last;
                end
            end
            ST_EMIT: begin
                if (i_emit_done) begin
                    n_state = ST_IDLE;
                    rotate  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_rows_seen <= 2'd0;
            r_slot_new  <= '0;
            for (int i = 0; i < lrs_pkg::SLOT_N; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col <= last ? '0 : col_eff + 6'd1;
                if (last && rows_eff != 2'd2) begin
                    r_rows_seen <= rows_eff + 2'd1;
                end else begin
                    r_rows_seen <= rows_eff;
                end
                r_len[r_slot_new] <= {1'b0, col_eff} + 7'd1;
            end
            if (rotate) begin
                r_slot_new     <= slot_nx;
                r_len[slot_nx] <= '0;
            end
        end
    end

    // request payload held for the write cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wcol  <= col_eff;
            r_alive <= i_cell.cell_alive;
            r_last  <= last;
            r_emit  <= (rows_eff == 2'd2);
        end
    end

    `LRS_ASSERT(a_write_follows_accept, i_clk, i_rst_n, (r_state == ST_WRITE) |-> $past(accept), "write cycle without a prior request")
    `LRS_NEVER(a_slot_range, i_clk, i_rst_n, r_slot_new == 2'd3, "row slot pointer out of range")
    `LRS_ASSERT(a_emit_needs_rows, i_clk, i_rst_n, o_ctl.start |-> (r_rows_seen == 2'd2), "emission started without two held rows")

endmodule

@@ hdl/lrs_emitter.sv @@
`include "assert_macros.svh"

module lrs_emitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrs_pkg::t_emit_ctl          i_ctl,
    input  logic [lrs_pkg::COL_W-1:0]   i_w_m1,
    output logic                        o_rd_en,
    output logic [lrs_pkg::COL_W-1:0]   o_rd_col,
    input  logic [lrs_pkg::SLOT_N-1:0]  i_rd_data,
    output logic                        o_done,
    lrs_result_if.source                o_result
);

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    logic                         r_busy;
    logic [lrs_pkg::CFG_W-1:0]    r_k;
    logic                         r_rd_vld;
    logic [lrs_pkg::CFG_W-1:0]    r_rd_k;
    logic [lrs_pkg::COL_W-1:0]    r_rd_col;
    logic [2:0]                   r_win_l;
    logic [2:0]                   r_win_c;
    logic                         r_out_vld;
    logic                         r_out_alive;
    logic [lrs_pkg::COL_W-1:0]    r_out_col;
    logic                         r_out_done;

    logic [lrs_pkg::CFG_W-1:0]    last_k;
    logic                         want;
    logic                         produce;
    logic                         consume;
    logic                         load;
    logic                         rd_fire;
    logic [2:0]                   cur;
    logic [3:0]                   nbrs;
    logic                         next_alive;

    // column sequence: last column, then 0 .. w-1, then 0 again
    assign last_k = {1'b0, i_w_m1} + 7'd2;
    assign want   = r_busy && (r_k <= last_k);

    always_comb begin
        if (r_k == '0) begin
            o_rd_col = i_w_m1;
        end else if (r_k == last_k) begin
            o_rd_col = '0;
        end else begin
            o_rd_col = lrs_pkg::COL_W'(r_k - 7'd1);
        end
    end

    // pipeline advance, stalled by the result register
    assign produce = (r_rd_k >= 7'd2);
    assign consume = r_rd_vld && (!produce || !r_out_vld || o_result.ready);
    assign load    = consume && produce;
    assign rd_fire = want && (!r_rd_vld || consume);
    assign o_rd_en = rd_fire;
    assign o_done  = consume && (r_rd_k == last_k);

    // column bits in row order up, mid, down; masked past each row's fill
    assign cur[0] = i_rd_data[i_ctl.slot_up]   & ({1'b0, r_rd_col} < i_ctl.len_up);
    assign cur[1] = i_rd_data[i_ctl.slot_mid]  & ({1'b0, r_rd_col} < i_ctl.len_mid);
    assign cur[2] = i_rd_data[i_ctl.slot_down] & ({1'b0, r_rd_col} < i_ctl.len_down);

    // neighbour count and b3/s23 rule
    assign nbrs = 4'(r_win_l[0]) + 4'(r_win_l[1]) + 4'(r_win_l[2])
                + 4'(r_win_c[0]) + 4'(r_win_c[2])
                + 4'(cur[0]) + 4'(cur[1]) + 4'(cur[2]);
    assign next_alive = (nbrs == BIRTH_COUNT) || ((nbrs == SURVIVE_COUNT) && r_win_c[1]);

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else begin
                if (o_done) begin
                    r_busy <= 1'b0;
                end
                if (rd_fire) begin
                    r_k <= r_k + 7'd1;
                end
            end
            if (rd_fire) begin
                r_rd_vld <= 1'b1;
            end else if (consume) begin
                r_rd_vld <= 1'b0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // read tag, window and result payload
    always_ff @(posedge i_clk) begin
        if (rd_fire) begin
            r_rd_k   <= r_k;
            r_rd_col <= o_rd_col;
        end
        if (consume) begin
            r_win_l <= r_win_c;
            r_win_c <= cur;
        end
        if (load) begin
            r_out_alive <= next_alive;
            r_out_col   <= lrs_pkg::COL_W'(r_rd_k - 7'd2);
            r_out_done  <= (r_rd_k == last_k);
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.next_alive  = r_out_alive;
    assign o_result.cell_column = r_out_col;
    assign o_result.row_done    = r_out_done;

    `LRS_NEVER(a_read_when_idle, i_clk, i_rst_n, rd_fire && !r_busy, "column read outside a burst")
    `LRS_NEVER(a_start_when_busy, i_clk, i_rst_n, i_ctl.start && r_busy, "burst started while one runs")
    `LRS_ASSERT(a_no_overwrite, i_clk, i_rst_n, load |-> (!r_out_vld || o_result.ready), "result overwritten before taken")

endmodule

@@ hdl/life_row_stencil.sv @@
// channel    dir  handshake     payload
// i_cell     in   valid/ready   cell_alive, slab_start
// o_result   out  valid/ready   next_alive, cell_column, row_done
// i_cfg      in   valid/ready   row_width
//
// each cell request reads the column entry of the row memory in its accept cycle
// and writes it back with the new bit in the next cycle.
// a completed row with two rows held starts a burst: w+2 column reads at one per
// cycle while o_result is taken. i_rst_n is synchronous; the row memory is not
// cleared, per-row fill counts mask columns not yet written. a stalled o_result
// stalls the burst in place.
module life_row_stencil #(
    parameter int MAX_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lrs_cell_if.sink        i_cell,
    lrs_result_if.source    o_result,
    lrs_cfg_if.sink         i_cfg
);

    localparam logic [lrs_pkg::CFG_W-1:0] MAX_W = lrs_pkg::CFG_W'(MAX_WIDTH);

    logic [lrs_pkg::CFG_W-1:0]    r_row_width;
    logic [lrs_pkg::CFG_W-1:0]    eff_width;
    logic [lrs_pkg::COL_W-1:0]    w_m1;

    logic                         wr_rd_en;
    logic [lrs_pkg::COL_W-1:0]    wr_rd_col;
    logic                         em_rd_en;
    logic [lrs_pkg::COL_W-1:0]    em_rd_col;
    logic [lrs_pkg::SLOT_N-1:0]   rd_data;
    logic                         wr_en;
    logic [lrs_pkg::COL_W-1:0]    wr_col;
    logic [lrs_pkg::SLOT_N-1:0]   wr_data;
    lrs_pkg::t_emit_ctl           emit_ctl;
    logic                         emit_done;

    // row width register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= lrs_pkg::WIDTH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_row_width <= i_cfg.row_width;
        end
    end

    // clamp to the supported width range
    always_comb begin
        if (r_row_width < lrs_pkg::MIN_WIDTH) begin
            eff_width = lrs_pkg::MIN_WIDTH;
        end else if (r_row_width > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = r_row_width;
        end
    end
    assign w_m1 = lrs_pkg::COL_W'(eff_width - 7'd1);

    // cell intake and read-modify-write
    lrs_writer u_writer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (i_cell),
        .i_w_m1      (w_m1),
        .o_rd_en     (wr_rd_en),
        .o_rd_col    (wr_rd_col),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_col    (wr_col),
        .o_wr_data   (wr_data),
        .o_ctl       (emit_ctl),
        .i_emit_done (emit_done)
    );

    // row memory, read port shared by intake and burst
    lrs_row_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (wr_rd_en || em_rd_en),
        .i_rd_col  (em_rd_en ? em_rd_col : wr_rd_col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_col  (wr_col),
        .i_wr_data (wr_data)
    );

    // next-generation burst
    lrs_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (emit_ctl),
        .i_w_m1    (w_m1),
        .o_rd_en   (em_rd_en),
        .o_rd_col  (em_rd_col),
        .i_rd_data (rd_data),
        .o_done    (emit_done),
        .o_result  (o_result)
    );

endmodule
